>>> rtl/alu_32bit_with_flags_macros.svh
// assertion macros for the alu pipeline
// no dependencies
`ifndef ALU_32BIT_WITH_FLAGS_MACROS_SVH
`define ALU_32BIT_WITH_FLAGS_MACROS_SVH

// implication checked every cycle outside reset
`define ALU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/alu_pkg.sv
// shared types and constants for the 32-bit alu
// no dependencies
package alu_pkg;

   localparam int unsigned WordBits = 32;
   localparam int unsigned StageCount = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_AND = 4'd4,
      OP_OR  = 4'd5,
      OP_XOR = 4'd6,
      OP_NOT = 4'd7,
      OP_SHL = 4'd8,
      OP_SHR = 4'd9,
      OP_ROL = 4'd10,
      OP_ROR = 4'd11,
      OP_CMP = 4'd12
   } op_type;

   // result of one item as it travels down the pipe
   typedef struct packed {
      logic [WordBits-1:0] value;
      logic                carry;
      logic                ovf;
      logic                ok;
   } res_type;

endpackage

>>> rtl/alu_div.sv
// unsigned restoring divider, one quotient bit per pipeline stage
// depends on alu_pkg
module alu_div (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [alu_pkg::WordBits-1:0]  dividend,
   input  logic [alu_pkg::WordBits-1:0]  divisor,
   output logic [alu_pkg::WordBits-1:0]  quotient
);
   import alu_pkg::*;

   localparam int unsigned W = WordBits;

   logic [W-1:0] rem_ff [W];
   logic [W-1:0] quo_ff [W];
   logic [W-1:0] den_ff [W];
   logic [W-1:0] rem_in [W];
   logic [W-1:0] quo_in [W];
   logic [W-1:0] den_in [W];

   always_comb begin
      logic [W:0]   part_v;
      logic [W:0]   diff_v;
      logic [W-1:0] rem_prev;
      logic [W-1:0] quo_prev;
      for (int s = 0; s < W; s++) begin
         if (s == 0) begin
            rem_prev  = '0;
            quo_prev  = dividend;
            den_in[s] = divisor;
         end else begin
            rem_prev  = rem_ff[s-1];
            quo_prev  = quo_ff[s-1];
            den_in[s] = den_ff[s-1];
         end
         part_v = {rem_prev, quo_prev[W-1]};
         diff_v = part_v - {1'b0, den_in[s]};
         if (!diff_v[W]) begin
            rem_in[s] = diff_v[W-1:0];
            quo_in[s] = {quo_prev[W-2:0], 1'b1};
         end else begin
            rem_in[s] = part_v[W-1:0];
            quo_in[s] = {quo_prev[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < W; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_in[s];
         end
      end
   end

   assign quotient = quo_ff[W-1];

endmodule

>>> rtl/alu_32bit_with_flags.sv
// 32-bit alu with nzcv flags, top level
// depends on alu_pkg, alu_div and alu_32bit_with_flags_macros.svh
//
// one request per cycle, sustained unless rsp_ready stalls the pipe. the
// depth of the pipe is set by the divider, which retires one quotient bit
// per stage; every other operation is computed in stage one (the multiply
// as two halves registered in stage one and summed in stage two) and then
// rides a delay line of the same length so results leave in order. the
// whole pipe moves only when the output stage is free or being drained,
// so a stall on rsp_ready freezes every stage and loses nothing. divide by
// zero and opcodes 13 to 15 give result_valid low with value and flags zero.
module alu_32bit_with_flags (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_op,
   input  logic [alu_pkg::WordBits-1:0] req_operand_a,
   input  logic [alu_pkg::WordBits-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [alu_pkg::WordBits-1:0] rsp_result_value,
   output logic                         rsp_zero_flag,
   output logic                         rsp_negative_flag,
   output logic                         rsp_carry_flag,
   output logic                         rsp_overflow_flag,
   output logic                         rsp_result_valid
);
   import alu_pkg::*;
   `include "alu_32bit_with_flags_macros.svh"

   localparam int unsigned W = WordBits;
   localparam int unsigned N = StageCount;

   // pipe advances whenever the last stage is empty or being taken
   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage one: everything but mul and div
   res_type      s1_in;
   logic [7:0]   amt;
   logic [4:0]   rot;
   logic [W:0]   sum;
   logic [W:0]   dif;
   logic [W-1:0] rol_v;
   logic [W-1:0] ror_v;

   always_comb begin
      amt   = req_operand_b[7:0];
      rot   = amt[4:0];
      sum   = {1'b0, req_operand_a} + {1'b0, req_operand_b};
      dif   = {1'b0, req_operand_a} - {1'b0, req_operand_b};
      rol_v = (req_operand_a << rot) | (req_operand_a >> (6'(W) - {1'b0, rot}));
      ror_v = (req_operand_a >> rot) | (req_operand_a << (6'(W) - {1'b0, rot}));
      s1_in = '{value: '0, carry: 1'b0, ovf: 1'b0, ok: 1'b1};
      case (req_op)
         OP_ADD: begin
            s1_in.value = sum[W-1:0];
            s1_in.carry = sum[W];
            s1_in.ovf   = (req_operand_a[W-1] ^ sum[W-1]) & (req_operand_b[W-1] ^ sum[W-1]);
         end
         OP_SUB: begin
            s1_in.value = dif[W-1:0];
            s1_in.carry = dif[W];
            s1_in.ovf   = (req_operand_a[W-1] ^ req_operand_b[W-1])
                        & (req_operand_a[W-1] ^ dif[W-1]);
         end
         OP_CMP: begin
            s1_in.value = dif[W-1:0];
            s1_in.carry = dif[W];
         end
         OP_MUL: ;
         OP_DIV: s1_in.ok = (req_operand_b != '0);
         OP_AND: s1_in.value = req_operand_a & req_operand_b;
         OP_OR:  s1_in.value = req_operand_a | req_operand_b;
         OP_XOR: s1_in.value = req_operand_a ^ req_operand_b;
         OP_NOT: s1_in.value = ~req_operand_a;
         OP_SHL: begin
            if (amt < 8'(W)) begin
               s1_in.value = req_operand_a << amt;
               // 32 minus the amount, modulo the word
               if (amt != '0) s1_in.carry = req_operand_a[5'd0 - amt[4:0]];
            end
         end
         OP_SHR: begin
            if (amt < 8'(W)) begin
               s1_in.value = req_operand_a >> amt;
               if (amt != '0) s1_in.carry = req_operand_a[amt[4:0] - 5'd1];
            end
         end
         OP_ROL: begin
            s1_in.value = (rot == '0) ? req_operand_a : rol_v;
            s1_in.carry = (rot != '0) & rol_v[0];
         end
         OP_ROR: begin
            s1_in.value = (rot == '0) ? req_operand_a : ror_v;
            s1_in.carry = (rot != '0) & ror_v[W-1];
         end
         default: s1_in.ok = 1'b0;
      endcase
   end

   // multiplier split in 16-bit halves of b: two 32x16 products in stage one, summed in stage two
   logic [W+15:0] plo_ff, phi_ff;
   logic [2*W-1:0] prod_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         plo_ff  <= req_operand_a * req_operand_b[15:0];
         phi_ff  <= req_operand_a * req_operand_b[W-1:16];
         prod_ff <= {16'b0, plo_ff} + {phi_ff, 16'b0};
      end
   end

   // control and result delay line
   logic [N-1:0] vld_ff;
   op_type       op_ff  [N];
   res_type      res_ff [N];
   res_type      s2_in;
   logic [W-1:0] quotient;

   alu_div u_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (req_operand_a),
      .divisor  (req_operand_b),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-2:0], req_valid};
      end
   end

   // fold in the product once it is ready after stage two
   always_comb begin
      s2_in = res_ff[1];
      if (op_ff[1] == OP_MUL) begin
         s2_in.value = prod_ff[W-1:0];
         s2_in.ovf   = (prod_ff[2*W-1:W] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0]  <= op_type'(req_op);
         res_ff[0] <= s1_in;
         res_ff[1] <= res_ff[0];
         res_ff[2] <= s2_in;
         for (int i = 1; i < N; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
         for (int i = 3; i < N; i++) begin
            res_ff[i] <= res_ff[i-1];
         end
      end
   end

   res_type fin;
   always_comb begin
      fin = res_ff[N-1];
      if (op_ff[N-1] == OP_DIV && fin.ok) fin.value = quotient;
      if (!fin.ok) fin = '0;
   end

   assign rsp_valid         = vld_ff[N-1];
   assign rsp_result_value  = fin.value;
   assign rsp_zero_flag     = fin.ok && (fin.value == '0);
   assign rsp_negative_flag = fin.value[W-1];
   assign rsp_carry_flag    = fin.carry;
   assign rsp_overflow_flag = fin.ovf;
   assign rsp_result_valid  = fin.ok;

   // stalled output freezes the whole pipe
   `ALU_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value), "result changed while stalled")
   // invalid results carry no flags
   `ALU_ASSERT_IMP(a_inv, rsp_valid && !rsp_result_valid, !rsp_zero_flag && !rsp_carry_flag && !rsp_overflow_flag && rsp_result_value == '0, "invalid result not cleared")
   // zero flag matches value for valid results
   `ALU_ASSERT_IMP(a_zero, rsp_valid && rsp_result_valid, rsp_zero_flag == (rsp_result_value == '0), "zero flag mismatch")

endmodule
